[hdl/tsca_pkg.sv]
// shared types and constants for the texture slot cache
`default_nettype none
package tsca_pkg;

  localparam logic [2:0] ST_SAME     = 3'd0;
  localparam logic [2:0] ST_HIT      = 3'd1;
  localparam logic [2:0] ST_FRESH    = 3'd2;
  localparam logic [2:0] ST_RECYCLED = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_OFF      = 3'd5;
  localparam logic [2:0] ST_MAINT    = 3'd6;

  localparam logic [1:0] OP_ACCESS = 2'd0;
  localparam logic [1:0] OP_AGE    = 2'd1;
  localparam logic [1:0] OP_SWEEP  = 2'd2;
  localparam logic [1:0] OP_FLUSH  = 2'd3;

  localparam logic REG_TEX_ON    = 1'b0;
  localparam logic REG_THRESHOLD = 1'b1;

  localparam logic [7:0] THRESHOLD_RESET = 8'd200;
  localparam logic [7:0] IDLE_MAX        = 8'd255;
  localparam logic [6:0] FREED_MAX       = 7'd127;

  // controller to datapath
  typedef struct packed {
    logic start;     // load request, clear scan pointer
    logic scan;      // walk one slot
    logic finish;    // apply result of the walk
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;      // scan pointer at final slot
    logic quick;     // access resolved without a walk
    logic hit;       // hit found during access walk
  } dp_stat_t;

endpackage
`default_nettype wire

[hdl/tsca_ctrl.sv]
// controller state machine for the texture slot cache
`default_nettype none
module tsca_ctrl
  import tsca_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output dp_cmd_t       cmd,
  input  dp_stat_t      stat
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECIDE = 6'b000010,
    S_SCAN   = 6'b000100,
    S_DRAIN  = 6'b001000,
    S_FINISH = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.quick) begin
          cmd.finish = 1'b1;
          state_next = S_OUT;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        // table reads are registered, so a hit stops the walk late
        if (stat.hit) begin
          state_next = S_FINISH;
        end else begin
          cmd.scan = 1'b1;
          if (stat.last) state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule
`default_nettype wire

[hdl/tsca_datapath.sv]
// slot tables, free stack and counters of the texture slot cache
`default_nettype none
module tsca_datapath
  import tsca_pkg::*;
#(
  parameter int ENTRIES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [1:0]  op,
  input  wire logic [31:0] tex_id,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  dp_cmd_t          cmd,
  output dp_stat_t         stat,
  output logic [2:0]       status,
  output logic [5:0]       handle,
  output logic             tex_enable,
  output logic [6:0]       freed_count,
  output logic [31:0]      new_count
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  logic [ENTRIES-1:0] slot_valid;
  logic [31:0] slot_key [ENTRIES];
  logic [5:0]  slot_handle [ENTRIES];
  logic [7:0]  slot_idle [ENTRIES];
  logic [5:0]  free_stack [ENTRIES];
  logic [CW-1:0] free_depth, next_fresh;
  logic [31:0] current_id, miss_loads, id_r;
  logic enable_flag, tex_on;
  logic [7:0] threshold;
  logic [1:0] op_r;
  logic [AW-1:0] ptr, pidx, empty_idx, top_idx;
  logic proc;
  logic empty_found;
  logic [6:0] freed;
  logic hit_r;
  logic [5:0] hit_handle;
  logic quick;

  // registered table reads, slot pidx is processed the cycle after its read
  logic [31:0] rd_key;
  logic [5:0]  rd_handle, stack_top;
  logic [7:0]  rd_idle;

  logic pvalid, pmatch, evict, recycle, can_load, load_now;
  logic idle_we;
  logic [AW-1:0] idle_wa;
  logic [7:0] idle_wd;
  logic [5:0] load_handle;

  assign pvalid  = slot_valid[pidx];
  assign pmatch  = pvalid && (rd_key == id_r);
  assign top_idx = free_depth[AW-1:0] - AW'(1);

  assign quick = (op_r == OP_ACCESS) &&
                 (!tex_on || id_r == 32'd0 || id_r == current_id);
  assign stat.quick = quick;
  assign stat.last  = (ptr == AW'(ENTRIES - 1));
  assign stat.hit   = proc && op_r == OP_ACCESS && pmatch;

  assign evict = proc && pvalid && (op_r == OP_FLUSH ||
                 (op_r == OP_SWEEP && rd_idle > threshold));

  assign recycle     = free_depth != '0;
  assign can_load    = empty_found && (recycle || next_fresh < CW'(ENTRIES));
  assign load_now    = cmd.finish && op_r == OP_ACCESS && !quick && !hit_r && can_load;
  assign load_handle = recycle ? stack_top : 6'(next_fresh);

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_on <= 1'b1;
      threshold <= THRESHOLD_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_TEX_ON) tex_on <= cfg_data[0];
      else threshold <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r <= op;
      id_r <= tex_id;
    end
    pidx <= ptr;
  end

  // key and handle tables
  always_ff @(posedge clk) begin
    if (load_now) begin
      slot_key[empty_idx] <= id_r;
      slot_handle[empty_idx] <= load_handle;
    end
    rd_key <= slot_key[ptr];
    rd_handle <= slot_handle[ptr];
  end

  always_comb begin
    idle_we = 1'b0;
    idle_wa = pidx;
    idle_wd = '0;
    if (proc && op_r == OP_AGE && pvalid && rd_idle != IDLE_MAX) begin
      idle_we = 1'b1;
      idle_wd = rd_idle + 8'd1;
    end else if (stat.hit) begin
      idle_we = 1'b1;
    end else if (load_now) begin
      idle_we = 1'b1;
      idle_wa = empty_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (idle_we) slot_idle[idle_wa] <= idle_wd;
    rd_idle <= slot_idle[ptr];
  end

  // free handle stack, top read ahead for a recycled load
  always_ff @(posedge clk) begin
    if (evict && free_depth < CW'(ENTRIES))
      free_stack[free_depth[AW-1:0]] <= rd_handle;
    stack_top <= free_stack[top_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      free_depth <= '0;
      next_fresh <= '0;
      current_id <= '0;
      enable_flag <= 1'b0;
      miss_loads <= '0;
      ptr <= '0;
      proc <= 1'b0;
      empty_found <= 1'b0;
      hit_r <= 1'b0;
      freed <= '0;
    end else begin
      proc <= cmd.scan;
      if (cmd.start) begin
        ptr <= '0;
        empty_found <= 1'b0;
        hit_r <= 1'b0;
        freed <= '0;
      end
      if (cmd.scan && !stat.last) ptr <= ptr + AW'(1);
      if (proc && op_r == OP_ACCESS) begin
        if (pmatch) begin
          hit_r <= 1'b1;
          hit_handle <= rd_handle;
        end
        if (!pvalid && !empty_found) begin
          empty_found <= 1'b1;
          empty_idx <= pidx;
        end
      end
      if (evict) begin
        slot_valid[pidx] <= 1'b0;
        if (free_depth < CW'(ENTRIES)) free_depth <= free_depth + CW'(1);
        if (freed != FREED_MAX) freed <= freed + 7'd1;
      end
      if (cmd.finish) begin
        if (op_r != OP_ACCESS) begin
          status <= ST_MAINT;
          handle <= '0;
        end else if (!tex_on || id_r == 32'd0) begin
          enable_flag <= 1'b0;
          status <= ST_OFF;
          handle <= '0;
        end else if (id_r == current_id) begin
          enable_flag <= 1'b1;
          status <= ST_SAME;
          handle <= '0;
        end else if (hit_r) begin
          enable_flag <= 1'b1;
          current_id <= id_r;
          status <= ST_HIT;
          handle <= hit_handle;
        end else if (can_load) begin
          slot_valid[empty_idx] <= 1'b1;
          miss_loads <= miss_loads + 32'd1;
          current_id <= id_r;
          enable_flag <= 1'b1;
          handle <= load_handle;
          if (recycle) begin
            free_depth <= free_depth - CW'(1);
            status <= ST_RECYCLED;
          end else begin
            next_fresh <= next_fresh + CW'(1);
            status <= ST_FRESH;
          end
        end else begin
          status <= ST_FULL;
          handle <= '0;
        end
      end
    end
  end

  assign tex_enable  = enable_flag;
  assign freed_count = (op_r == OP_ACCESS) ? 7'd0 : freed;
  assign new_count   = miss_loads;

endmodule
`default_nettype wire

[hdl/texture_slot_cache_aging.sv]
// texture slot cache top level: id to handle table with aging and free stack
// an access with texturing off, id zero or same id is resolved without walking the table
// other accesses walk the table until a hit or its last slot; age, sweep and flush walk every slot
// one request in flight; the next is accepted the cycle after the result is taken
// synchronous reset clears valid bits, counters and state; tables need no clearing
`default_nettype none
module texture_slot_cache_aging
  import tsca_pkg::*;
#(
  parameter int ENTRIES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  op,
  input  wire logic [31:0] tex_id,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [5:0]       handle,
  output logic             tex_enable,
  output logic [6:0]       freed_count,
  output logic [31:0]      new_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  tsca_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .stat
  );

  tsca_datapath #(.ENTRIES(ENTRIES)) u_dp (
    .clk, .rst, .op, .tex_id, .cfg_valid, .cfg_index, .cfg_data, .cmd, .stat,
    .status, .handle, .tex_enable, .freed_count, .new_count
  );

endmodule
`default_nettype wire
